// ===== rtl/ppcoe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppcoe_pkg
// Types, codes and constants shared by the clock offset estimator files.
// ----------------------------------------------------------------------------
package ppcoe_pkg;

	localparam int COUNT_BITS = 32;
	localparam int TIME_BITS  = 64;
	localparam int OUT_COUNT_BITS = 32;

	localparam logic       FUNC_TICK = 1'b0;
	localparam logic       FUNC_PONG = 1'b1;

	localparam logic [15:0] PONG_BYTES   = 16'd18;
	localparam logic [7:0]  PING_VERSION = 8'd1;
	localparam logic [7:0]  PONG_MSG_ID  = 8'd2;

	localparam logic [2:0] ST_PING_SENT = 3'd0;
	localparam logic [2:0] ST_SEND_FAIL = 3'd1;
	localparam logic [2:0] ST_BAD_LEN   = 3'd2;
	localparam logic [2:0] ST_BAD_VER   = 3'd3;
	localparam logic [2:0] ST_BAD_ID    = 3'd4;
	localparam logic [2:0] ST_MISMATCH  = 3'd5;
	localparam logic [2:0] ST_ACCEPTED  = 3'd6;

	typedef logic [TIME_BITS-1:0]  time_t;
	typedef logic [COUNT_BITS-1:0] count_t;

	typedef struct packed {
		logic        func;
		time_t       local_time;
		logic        send_ok;
		logic [15:0] pong_length;
		logic [7:0]  pong_version;
		logic [7:0]  pong_msg_id;
		time_t       pong_echo_time;
		time_t       pong_server_time;
	} in_item_t;

	typedef struct packed {
		logic                      ping_valid;
		time_t                     ping_stamp;
		logic [2:0]                status;
		logic signed [TIME_BITS-1:0] offset_out;
		logic [OUT_COUNT_BITS-1:0] pings_sent_out;
		logic [OUT_COUNT_BITS-1:0] pongs_received_out;
		time_t                     last_pong_time_out;
	} out_item_t;

	typedef struct packed {
		logic [2:0] status;
		logic       ping_keep;
		logic       pong_take;
	} check_t;

	typedef struct packed {
		time_t  kept_stamp;
		time_t  offset;
		count_t ping_count;
		count_t pong_count;
		time_t  last_pong;
	} state_t;

	function automatic logic [OUT_COUNT_BITS-1:0] count_out(input count_t c);
		logic [63:0] wide;
		wide = 64'(c);
		return wide[OUT_COUNT_BITS-1:0];
	endfunction

endpackage

// ===== rtl/ppcoe_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppcoe_in_if / ppcoe_out_if
// Valid/ready channels for event items and result items.
// ----------------------------------------------------------------------------
interface ppcoe_in_if import ppcoe_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface ppcoe_out_if import ppcoe_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/ppcoe_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppcoe_check
// Classifies one event: ping send outcome or pong checks in priority order.
// ----------------------------------------------------------------------------
module ppcoe_check import ppcoe_pkg::*; (
	input  in_item_t item,
	input  time_t    kept_stamp,
	output check_t   chk
);

	always_comb begin
		chk.ping_keep = 1'b0;
		chk.pong_take = 1'b0;
		if (item.func == FUNC_TICK) begin
			chk.ping_keep = item.send_ok;
			chk.status    = item.send_ok ? ST_PING_SENT : ST_SEND_FAIL;
		end else if (item.pong_length != PONG_BYTES) begin
			chk.status = ST_BAD_LEN;
		end else if (item.pong_version != PING_VERSION) begin
			chk.status = ST_BAD_VER;
		end else if (item.pong_msg_id != PONG_MSG_ID) begin
			chk.status = ST_BAD_ID;
		end else if (item.pong_echo_time != kept_stamp) begin
			chk.status = ST_MISMATCH;
		end else begin
			chk.status    = ST_ACCEPTED;
			chk.pong_take = 1'b1;
		end
	end

endmodule

// ===== rtl/ppcoe_state.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppcoe_state
// Kept stamp, offset estimate, counters and last pong time, with the
// offset update for an accepted pong.
// ----------------------------------------------------------------------------
module ppcoe_state import ppcoe_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     update,
	input  in_item_t item,
	input  check_t   chk,
	output state_t   st,
	output state_t   st_next
);

	state_t st_q;
	time_t  rtt;
	time_t  half_rtt;

	always_comb begin
		rtt      = item.local_time - st_q.kept_stamp;
		half_rtt = {1'b0, rtt[TIME_BITS-1:1]};
		st_next  = st_q;
		if (chk.ping_keep) begin
			st_next.ping_count = st_q.ping_count + count_t'(1);
			st_next.kept_stamp = item.local_time;
		end
		if (chk.pong_take) begin
			st_next.offset     = item.pong_server_time - half_rtt - st_q.kept_stamp;
			st_next.pong_count = st_q.pong_count + count_t'(1);
			st_next.last_pong  = item.local_time;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (update) begin
			st_q <= st_next;
		end
	end

	assign st = st_q;

endmodule

// ===== rtl/ping_pong_clock_offset_estimator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ping_pong_clock_offset_estimator
// Client side of a two-way time-sync exchange: issues pings on timer ticks,
// checks pongs and keeps the server minus local offset estimate.
// ----------------------------------------------------------------------------
// Every event transfer yields one result: the event is registered, then
// the checks, the offset subtract chain and the state update close into
// the result register. A new event is taken in every cycle while ready is
// high; ready drops only while a registered event waits behind a result
// that the sink has not taken. Counters wrap at COUNT_BITS and the offset
// arithmetic wraps modulo 2^64.
module ping_pong_clock_offset_estimator import ppcoe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	ppcoe_in_if.sink    events,
	ppcoe_out_if.source results
);

	logic      valid_s1;
	in_item_t  item_s1;
	logic      res_valid_q;
	out_item_t res_q;
	logic      stall;
	logic      advance;
	check_t    chk;
	state_t    st;
	state_t    st_next;

	assign stall        = res_valid_q && !results.ready;
	assign advance      = valid_s1 && !stall;
	assign events.ready = !(valid_s1 && stall);

	ppcoe_check u_check (
		.item       (item_s1),
		.kept_stamp (st.kept_stamp),
		.chk        (chk)
	);

	ppcoe_state u_state (
		.clk     (clk),
		.arst_n  (arst_n),
		.update  (advance),
		.item    (item_s1),
		.chk     (chk),
		.st      (st),
		.st_next (st_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (events.ready) begin
			valid_s1 <= events.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (events.valid && events.ready) begin
			item_s1 <= events.payload;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q.ping_valid         <= (item_s1.func == FUNC_TICK);
			res_q.ping_stamp         <= (item_s1.func == FUNC_TICK) ? item_s1.local_time : '0;
			res_q.status             <= chk.status;
			res_q.offset_out         <= st_next.offset;
			res_q.pings_sent_out     <= count_out(st_next.ping_count);
			res_q.pongs_received_out <= count_out(st_next.pong_count);
			res_q.last_pong_time_out <= st_next.last_pong;
		end
	end

	assign results.valid   = res_valid_q;
	assign results.payload = res_q;

endmodule

// ===== rtl/ppcoe_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppcoe_checker
// Port-level checks for the clock offset estimator, bound to the top level.
// ----------------------------------------------------------------------------
module ppcoe_checker import ppcoe_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_payload
);

	// a stalled result holds until its transfer
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_payload))
		else $error("result changed while stalled");

	// no result while in reset
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result valid during reset");

	// input back-pressure only behind a stalled result
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("ready low without output stall");

	// ping flag matches the tick status codes
	a_ping_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_payload.ping_valid ==
			(out_payload.status == ST_PING_SENT || out_payload.status == ST_SEND_FAIL))
		else $error("ping flag and status disagree");

	// pong results carry no ping stamp
	a_pong_stamp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_payload.ping_valid |-> out_payload.ping_stamp == '0)
		else $error("pong result with ping stamp");

endmodule

bind ping_pong_clock_offset_estimator ppcoe_checker u_ppcoe_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (events.ready),
	.out_valid   (results.valid),
	.out_ready   (results.ready),
	.out_payload (results.payload)
);
